[src/psp_pkg.sv]
// Package for the printf specification parser: character codes and helper functions.
package psp_pkg;

  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LC_C    = 8'h63;
  localparam logic [7:0] CH_LC_S    = 8'h73;
  localparam logic [7:0] CH_LC_P    = 8'h70;
  localparam logic [7:0] CH_LC_D    = 8'h64;
  localparam logic [7:0] CH_LC_I    = 8'h69;
  localparam logic [7:0] CH_LC_U    = 8'h75;
  localparam logic [7:0] CH_LC_X    = 8'h78;
  localparam logic [7:0] CH_UC_X    = 8'h58;

  localparam logic [31:0] ACC_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] ACC_MIN = 32'h8000_0000;

  function automatic logic is_type_char(input logic [7:0] c);
    logic r;
    case (c) inside
      CH_LC_C, CH_LC_S, CH_LC_P, CH_LC_D, CH_LC_I,
      CH_LC_U, CH_LC_X, CH_UC_X, CH_PERCENT: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Multiplies by ten, adds one digit and saturates at the signed 32-bit limits.
  function automatic logic [31:0] push_digit(input logic [31:0] acc, input logic [3:0] d);
    logic [36:0] ext;
    logic [36:0] sum;
    logic [31:0] r;
    ext = {{5{acc[31]}}, acc};
    sum = (ext << 3) + (ext << 1) + {33'd0, d};
    if (sum[36:31] == 6'b000000 || sum[36:31] == 6'b111111) begin
      r = sum[31:0];
    end else if (sum[36]) begin
      r = ACC_MIN;
    end else begin
      r = ACC_MAX;
    end
    return r;
  endfunction

endpackage

[src/printf_spec_parser_unit.sv]
// Top level of the printf conversion specification parser.
// The unit takes one character of a conversion specification per item, at one item per
// clock while no result waits untaken, and gives one result when the specification
// ends, in the cycle after the item that ends it, held in an output register. The
// first item of each specification is the introducer and is skipped. A type character
// ends the specification and is counted; any other unexpected character ends it and
// is dropped. Each item passes through a single stage of flag, accumulator and
// saturation logic, and the input stays ready while a waiting result is taken in the same cycle.
module printf_spec_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic [31:0] star_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        left_justify,
  output logic        zero_pad,
  output logic [30:0] field_width,
  output logic        width_present,
  output logic [30:0] field_precision,
  output logic        precision_present,
  output logic [7:0]  conversion,
  output logic        ended_by_type,
  output logic [15:0] consumed
);
  import psp_pkg::*;

  logic        in_spec, in_spec_next;
  logic        minus_seen, minus_seen_next;
  logic        zero_seen, zero_seen_next;
  logic [31:0] width_acc, width_acc_next;
  logic        width_seen, width_seen_next;
  logic [31:0] prec_acc, prec_acc_next;
  logic        dot_seen, dot_seen_next;
  logic [15:0] char_count, char_count_next;

  logic        accept;
  logic        emit;
  logic        is_digit;
  logic        is_type;
  logic [15:0] count_inc;
  logic [3:0]  digit_val;

  logic        res_left;
  logic [30:0] res_width;
  logic [30:0] res_prec;
  logic        res_prec_present;
  logic [7:0]  res_conv;
  logic [15:0] res_consumed;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_type   = is_type_char(ch);
  assign digit_val = 4'(ch - CH_ZERO);
  assign count_inc = (char_count == 16'hFFFF) ? char_count : char_count + 16'd1;

  always_comb begin
    in_spec_next    = in_spec;
    minus_seen_next = minus_seen;
    zero_seen_next  = zero_seen;
    width_acc_next  = width_acc;
    width_seen_next = width_seen;
    prec_acc_next   = prec_acc;
    dot_seen_next   = dot_seen;
    char_count_next = char_count;
    emit            = 1'b0;
    if (!in_spec) begin
      in_spec_next    = 1'b1;
      minus_seen_next = 1'b0;
      zero_seen_next  = 1'b0;
      width_acc_next  = '0;
      width_seen_next = 1'b0;
      prec_acc_next   = '0;
      dot_seen_next   = 1'b0;
      char_count_next = 16'd1;
    end else if (is_type || !(is_digit || ch == CH_MINUS || ch == CH_DOT || ch == CH_STAR)) begin
      emit            = 1'b1;
      in_spec_next    = 1'b0;
      minus_seen_next = 1'b0;
      zero_seen_next  = 1'b0;
      width_acc_next  = '0;
      width_seen_next = 1'b0;
      prec_acc_next   = '0;
      dot_seen_next   = 1'b0;
      char_count_next = '0;
    end else begin
      char_count_next = count_inc;
      if (ch == CH_ZERO && !minus_seen && !width_seen && !dot_seen) begin
        zero_seen_next = 1'b1;
      end
      if (ch == CH_MINUS) begin
        minus_seen_next = 1'b1;
      end else if (ch == CH_DOT) begin
        dot_seen_next = 1'b1;
      end else if (ch == CH_STAR) begin
        if (dot_seen) begin
          prec_acc_next = star_value;
        end else begin
          width_acc_next  = star_value;
          width_seen_next = 1'b1;
        end
      end else if (dot_seen) begin
        prec_acc_next = push_digit(prec_acc, digit_val);
      end else begin
        width_acc_next  = push_digit(width_acc, digit_val);
        width_seen_next = 1'b1;
      end
    end
  end

  always_comb begin
    res_left = minus_seen || width_acc[31];
    if (width_acc == ACC_MIN) begin
      res_width = ACC_MAX[30:0];
    end else if (width_acc[31]) begin
      res_width = 31'(-width_acc);
    end else begin
      res_width = width_acc[30:0];
    end
    res_prec         = prec_acc[31] ? 31'd0 : prec_acc[30:0];
    res_prec_present = dot_seen && !prec_acc[31];
    res_conv         = is_type ? ch : 8'd0;
    res_consumed     = is_type ? count_inc : char_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_spec    <= 1'b0;
      minus_seen <= 1'b0;
      zero_seen  <= 1'b0;
      width_acc  <= '0;
      width_seen <= 1'b0;
      prec_acc   <= '0;
      dot_seen   <= 1'b0;
      char_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        in_spec    <= in_spec_next;
        minus_seen <= minus_seen_next;
        zero_seen  <= zero_seen_next;
        width_acc  <= width_acc_next;
        width_seen <= width_seen_next;
        prec_acc   <= prec_acc_next;
        dot_seen   <= dot_seen_next;
        char_count <= char_count_next;
      end
      if (accept && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      left_justify      <= res_left;
      zero_pad          <= zero_seen;
      field_width       <= res_width;
      width_present     <= width_seen;
      field_precision   <= res_prec;
      precision_present <= res_prec_present;
      conversion        <= res_conv;
      ended_by_type     <= is_type;
      consumed          <= res_consumed;
    end
  end

endmodule

[src/psp_checker.sv]
// Port checker for the printf specification parser and its bind to the top level.
module psp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [30:0] field_precision,
  input logic        precision_present,
  input logic [7:0]  conversion,
  input logic        ended_by_type,
  input logic [15:0] consumed
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("A result is offered just after reset.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(consumed) && $stable(conversion))
    else $error("A waiting result item changed before it was taken.");

  a_conv_matches_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ended_by_type |-> conversion == 8'd0 && consumed != 16'd0)
    else $error("A result not ended by a type character carries a conversion.");

  a_prec_absent_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !precision_present |-> field_precision == 31'd0)
    else $error("An absent precision is not zero.");

endmodule

bind printf_spec_parser_unit psp_checker u_psp_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .field_precision   (field_precision),
  .precision_present (precision_present),
  .conversion        (conversion),
  .ended_by_type     (ended_by_type),
  .consumed          (consumed)
);
